### design/gs3_pkg.sv
// ----------------------------------------------------------------------------
// gs3_pkg
// Types, widths, stage latencies and rounding helpers shared by the 3x3
// Gram-Schmidt orthonormalization pipeline.
// ----------------------------------------------------------------------------
package gs3_pkg;

    // Input entries are signed Q3.28. The binary point has no effect on the
    // result, because every column is normalized to unit length.
    localparam int DATA_WIDTH = 32;
    localparam int MAG_W      = 32;          // prescaled magnitude, at most 2^31
    localparam int M_W        = MAG_W + 1;   // prescaled signed element
    localparam int W_W        = 36;          // column after projection removal
    localparam int Q_W        = 32;          // unit vector element, Q1.30
    localparam int D_W        = 36;          // rounded dot product
    localparam int SUM_W      = 2 * MAG_W;   // sum of squares
    localparam int ROOT_W     = SUM_W / 2;
    localparam int QB_W       = 31;          // quotient bits of one division
    localparam int NUM_W      = MAG_W + 31;  // dividend width
    localparam int POS_W      = 6;           // bit position within W_W

    localparam int NORM_LAT = 4;
    localparam int SQRT_LAT = ROOT_W;
    localparam int DIV_LAT  = QB_W;
    localparam int UNIT_LAT = NORM_LAT + 2 + SQRT_LAT + 1 + DIV_LAT + 1;
    localparam int PROJ_LAT = 4;

    typedef logic signed [W_W-1:0] wide_t;
    typedef logic [MAG_W-1:0]      mag_t;
    typedef logic signed [M_W-1:0] mval_t;
    typedef logic signed [Q_W-1:0] q_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] in_r0c0;
        logic signed [DATA_WIDTH-1:0] in_r1c0;
        logic signed [DATA_WIDTH-1:0] in_r2c0;
        logic signed [DATA_WIDTH-1:0] in_r0c1;
        logic signed [DATA_WIDTH-1:0] in_r1c1;
        logic signed [DATA_WIDTH-1:0] in_r2c1;
        logic signed [DATA_WIDTH-1:0] in_r0c2;
        logic signed [DATA_WIDTH-1:0] in_r1c2;
        logic signed [DATA_WIDTH-1:0] in_r2c2;
    } gs_in_t;

    typedef struct packed {
        logic signed [Q_W-1:0] out_r0c0;
        logic signed [Q_W-1:0] out_r1c0;
        logic signed [Q_W-1:0] out_r2c0;
        logic signed [Q_W-1:0] out_r0c1;
        logic signed [Q_W-1:0] out_r1c1;
        logic signed [Q_W-1:0] out_r2c1;
        logic signed [Q_W-1:0] out_r0c2;
        logic signed [Q_W-1:0] out_r1c2;
        logic signed [Q_W-1:0] out_r2c2;
        logic                  degenerate;
    } gs_out_t;

    // Divide by 2^30, rounding to nearest with halves away from zero.
    function automatic logic signed [39:0] rnd30(input logic signed [67:0] x);
        logic [67:0] mag;
        logic [67:0] biased;
        logic signed [39:0] res;
        mag    = x[67] ? 68'(-x) : 68'(x);
        biased = mag + (68'd1 << 29);
        res    = $signed({2'b00, biased[67:30]});
        return x[67] ? -res : res;
    endfunction

    function automatic mval_t to_signed(input mag_t mag, input logic neg);
        mval_t s;
        s = $signed({1'b0, mag});
        return neg ? -s : s;
    endfunction

endpackage

### design/gs3_delay.sv
// ----------------------------------------------------------------------------
// gs3_delay
// Enabled shift register that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module gs3_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

### design/gs3_norm.sv
// ----------------------------------------------------------------------------
// gs3_norm
// Prescales a three-element vector by a power of two so that its largest
// magnitude lands in [2^30, 2^31]. Right shifts truncate the magnitudes.
// ----------------------------------------------------------------------------
module gs3_norm (
    input  logic                aclk,
    input  logic                en,
    input  gs3_pkg::wide_t      v_i   [3],
    output gs3_pkg::mag_t       mag_o [3],
    output logic [2:0]          neg_o,
    output logic                nz_o
);

    localparam int W = gs3_pkg::W_W;
    localparam int PW = gs3_pkg::POS_W;

    logic [W-1:0]  a_mag_reg [3];
    logic [2:0]    a_neg_reg;
    logic [W-1:0]  a_max_reg;
    logic [W-1:0]  a_mag_next [3];
    logic [W-1:0]  a_max_next;

    logic [W-1:0]  b_mag_reg [3];
    logic [2:0]    b_neg_reg;
    logic [W-1:0]  b_max_reg;
    logic [PW-1:0] b_pos_reg;
    logic          b_nz_reg;
    logic [PW-1:0] b_pos_next;

    logic [W-1:0]  c_mag_reg [3];
    logic [2:0]    c_neg_reg;
    logic          c_nz_reg;
    logic [4:0]    c_left_reg;
    logic [2:0]    c_right_reg;
    logic [4:0]    c_left_next;
    logic [2:0]    c_right_next;

    gs3_pkg::mag_t d_mag_reg [3];
    logic [2:0]    d_neg_reg;
    logic          d_nz_reg;

    // Lanes take magnitudes; the merge keeps the largest.
    always_comb begin
        logic [W-1:0] m01;
        for (int i = 0; i < 3; i++) begin
            a_mag_next[i] = v_i[i][W-1] ? W'(-v_i[i]) : W'(v_i[i]);
        end
        m01 = (a_mag_next[0] > a_mag_next[1]) ? a_mag_next[0] : a_mag_next[1];
        a_max_next = (m01 > a_mag_next[2]) ? m01 : a_mag_next[2];
    end

    always_comb begin
        b_pos_next = '0;
        for (int i = 0; i < W; i++) begin
            if (a_max_reg[i]) begin
                b_pos_next = PW'(i);
            end
        end
    end

    // Above bit 30 the shift puts the top bit at 31 only if that gives
    // exactly 2^31; otherwise it goes one further, down to bit 30.
    always_comb begin
        logic [PW-1:0] k;
        logic [W-1:0]  top;
        k            = b_pos_reg - PW'(31);
        top          = b_max_reg >> k;
        c_left_next  = '0;
        c_right_next = '0;
        if (b_pos_reg < PW'(30)) begin
            c_left_next = 5'(PW'(30) - b_pos_reg);
        end else if (b_pos_reg > PW'(30)) begin
            if (top == (W'(1) << 31)) begin
                c_right_next = 3'(k);
            end else begin
                c_right_next = 3'(k + PW'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_mag_reg <= a_mag_next;
            a_neg_reg <= {v_i[2][W-1], v_i[1][W-1], v_i[0][W-1]};
            a_max_reg <= a_max_next;

            b_mag_reg <= a_mag_reg;
            b_neg_reg <= a_neg_reg;
            b_max_reg <= a_max_reg;
            b_pos_reg <= b_pos_next;
            b_nz_reg  <= |a_max_reg;

            c_mag_reg   <= b_mag_reg;
            c_neg_reg   <= b_neg_reg;
            c_nz_reg    <= b_nz_reg;
            c_left_reg  <= c_left_next;
            c_right_reg <= c_right_next;

            for (int i = 0; i < 3; i++) begin
                d_mag_reg[i] <= gs3_pkg::MAG_W'((c_mag_reg[i] << c_left_reg) >> c_right_reg);
            end
            d_neg_reg <= c_neg_reg;
            d_nz_reg  <= c_nz_reg;
        end
    end

    assign mag_o = d_mag_reg;
    assign neg_o = d_neg_reg;
    assign nz_o  = d_nz_reg;

endmodule

### design/gs3_isqrt.sv
// ----------------------------------------------------------------------------
// gs3_isqrt
// Pipelined integer square root, floor(sqrt(s)), one result bit per stage.
// ----------------------------------------------------------------------------
module gs3_isqrt (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [gs3_pkg::SUM_W-1:0]    s_i,
    output logic [gs3_pkg::ROOT_W-1:0]   root_o
);

    localparam int SW = gs3_pkg::SUM_W;
    localparam int N  = gs3_pkg::SQRT_LAT;

    logic [SW-1:0] rem_reg   [N];
    logic [SW-1:0] root_reg  [N];
    logic [SW-1:0] rem_next  [N];
    logic [SW-1:0] root_next [N];

    function automatic logic [2*SW-1:0] sq_step(input logic [SW-1:0] rem,
                                                input logic [SW-1:0] root,
                                                input logic [SW-1:0] bitv);
        logic [SW:0] trial;
        trial = {1'b0, root} + {1'b0, bitv};
        if ({1'b0, rem} >= trial) begin
            return {rem - trial[SW-1:0], (root >> 1) + bitv};
        end
        return {rem, root >> 1};
    endfunction

    always_comb begin
        {rem_next[0], root_next[0]} = sq_step(s_i, '0, SW'(1) << (SW - 2));
        for (int j = 1; j < N; j++) begin
            {rem_next[j], root_next[j]} =
                sq_step(rem_reg[j-1], root_reg[j-1], SW'(1) << (SW - 2 - 2 * j));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < N; j++) begin
                rem_reg[j]  <= rem_next[j];
                root_reg[j] <= root_next[j];
            end
        end
    end

    assign root_o = root_reg[N-1][gs3_pkg::ROOT_W-1:0];

endmodule

### design/gs3_unit.sv
// ----------------------------------------------------------------------------
// gs3_unit
// Scales a three-element column to unit length in Q1.30: prescale, squares
// in three lanes, merged sum, square root, then three divider lanes.
// ----------------------------------------------------------------------------
module gs3_unit (
    input  logic           aclk,
    input  logic           en,
    input  gs3_pkg::wide_t w_i [3],
    output gs3_pkg::q_t    q_o [3],
    output logic           nz_o
);

    localparam int MW = gs3_pkg::MAG_W;
    localparam int SW = gs3_pkg::SUM_W;
    localparam int RW = gs3_pkg::ROOT_W;
    localparam int NW = gs3_pkg::NUM_W;
    localparam int QB = gs3_pkg::QB_W;
    localparam int ND = gs3_pkg::DIV_LAT;
    localparam int SIDE_W = 3 * MW + 4;

    gs3_pkg::mag_t n_mag [3];
    logic [2:0]    n_neg;
    logic          n_nz;

    logic [SW-1:0] sq_reg [3];
    gs3_pkg::mag_t s_mag_reg [3];
    logic [2:0]    s_neg_reg;
    logic          s_nz_reg;

    logic [SW-1:0] sum_reg;
    gs3_pkg::mag_t t_mag_reg [3];
    logic [2:0]    t_neg_reg;
    logic          t_nz_reg;

    logic [RW-1:0]     root;
    logic [SIDE_W-1:0] side_d;
    logic [SIDE_W-1:0] side_q;
    gs3_pkg::mag_t     r_mag [3];
    logic [2:0]        r_neg;
    logic              r_nz;

    logic [NW-1:0] num_reg [3];
    logic [RW-1:0] den_reg;
    logic [2:0]    nneg_reg;
    logic          nnz_reg;

    logic [NW-1:0] drem_reg  [ND][3];
    logic [QB-1:0] quo_reg   [ND][3];
    logic [NW-1:0] drem_next [ND][3];
    logic [QB-1:0] quo_next  [ND][3];
    logic [RW-1:0] dden_reg  [ND];
    logic [2:0]    dneg_reg  [ND];
    logic          dnz_reg   [ND];

    gs3_pkg::q_t   q_reg [3];
    logic          nz_reg;

    function automatic logic [NW+QB-1:0] dv_step(input logic [NW-1:0] rem,
                                                 input logic [QB-1:0] quo,
                                                 input logic [NW-1:0] trial);
        if (rem >= trial) begin
            return {rem - trial, quo[QB-2:0], 1'b1};
        end
        return {rem, quo[QB-2:0], 1'b0};
    endfunction

    gs3_norm u_norm (
        .aclk  (aclk),
        .en    (en),
        .v_i   (w_i),
        .mag_o (n_mag),
        .neg_o (n_neg),
        .nz_o  (n_nz)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= n_mag[i] * n_mag[i];
            end
            s_mag_reg <= n_mag;
            s_neg_reg <= n_neg;
            s_nz_reg  <= n_nz;

            sum_reg   <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            t_mag_reg <= s_mag_reg;
            t_neg_reg <= s_neg_reg;
            t_nz_reg  <= s_nz_reg;
        end
    end

    gs3_isqrt u_isqrt (
        .aclk   (aclk),
        .en     (en),
        .s_i    (sum_reg),
        .root_o (root)
    );

    assign side_d = {t_mag_reg[0], t_mag_reg[1], t_mag_reg[2], t_neg_reg, t_nz_reg};

    gs3_delay #(
        .WIDTH (SIDE_W),
        .DEPTH (gs3_pkg::SQRT_LAT)
    ) u_side (
        .aclk (aclk),
        .en   (en),
        .d    (side_d),
        .q    (side_q)
    );

    assign r_mag[0] = side_q[SIDE_W-1 -: MW];
    assign r_mag[1] = side_q[SIDE_W-1-MW -: MW];
    assign r_mag[2] = side_q[SIDE_W-1-2*MW -: MW];
    assign r_neg    = side_q[3:1];
    assign r_nz     = side_q[0];

    // Dividend is |p| * 2^30 plus half the root, for a rounded quotient.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                num_reg[i] <= (NW'(r_mag[i]) << 30) + NW'(root[RW-1:1]);
            end
            den_reg  <= root;
            nneg_reg <= r_neg;
            nnz_reg  <= r_nz;
        end
    end

    // Restoring division, one quotient bit per stage in each lane.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            {drem_next[0][i], quo_next[0][i]} =
                dv_step(num_reg[i], '0, NW'(den_reg) << (QB - 1));
            for (int j = 1; j < ND; j++) begin
                {drem_next[j][i], quo_next[j][i]} =
                    dv_step(drem_reg[j-1][i], quo_reg[j-1][i],
                            NW'(dden_reg[j-1]) << (QB - 1 - j));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            drem_reg    <= drem_next;
            quo_reg     <= quo_next;
            dden_reg[0] <= den_reg;
            dneg_reg[0] <= nneg_reg;
            dnz_reg[0]  <= nnz_reg;
            for (int j = 1; j < ND; j++) begin
                dden_reg[j] <= dden_reg[j-1];
                dneg_reg[j] <= dneg_reg[j-1];
                dnz_reg[j]  <= dnz_reg[j-1];
            end
        end
    end

    // An all-zero column has no direction and comes out as zeros.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (!dnz_reg[ND-1]) begin
                    q_reg[i] <= '0;
                end else if (dneg_reg[ND-1][i]) begin
                    q_reg[i] <= -$signed({1'b0, quo_reg[ND-1][i]});
                end else begin
                    q_reg[i] <= $signed({1'b0, quo_reg[ND-1][i]});
                end
            end
            nz_reg <= dnz_reg[ND-1];
        end
    end

    assign q_o  = q_reg;
    assign nz_o = nz_reg;

endmodule

### design/gs3_proj.sv
// ----------------------------------------------------------------------------
// gs3_proj
// Removes the projection of a column on one unit vector: three product
// lanes, a merged and rounded dot product, then three subtracting lanes.
// ----------------------------------------------------------------------------
module gs3_proj (
    input  logic           aclk,
    input  logic           en,
    input  gs3_pkg::q_t    q_i    [3],
    input  gs3_pkg::mval_t m_i    [3],
    input  gs3_pkg::wide_t base_i [3],
    output gs3_pkg::wide_t w_o    [3]
);

    localparam int PW = gs3_pkg::Q_W + gs3_pkg::M_W;
    localparam int EW = gs3_pkg::D_W + gs3_pkg::Q_W;

    logic signed [PW-1:0] prod_reg [3];
    gs3_pkg::q_t          q1_reg   [3];
    gs3_pkg::wide_t       b1_reg   [3];

    logic signed [gs3_pkg::D_W-1:0] d_reg;
    gs3_pkg::q_t          q2_reg   [3];
    gs3_pkg::wide_t       b2_reg   [3];

    logic signed [EW-1:0] e_reg    [3];
    gs3_pkg::wide_t       b3_reg   [3];

    gs3_pkg::wide_t       w_reg    [3];

    logic signed [39:0]   d_rnd;
    logic signed [39:0]   e_rnd    [3];

    assign d_rnd = gs3_pkg::rnd30(68'(prod_reg[0]) + 68'(prod_reg[1]) + 68'(prod_reg[2]));

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e_rnd[i] = gs3_pkg::rnd30(e_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= q_i[i] * m_i[i];
                e_reg[i]    <= d_reg * q2_reg[i];
                w_reg[i]    <= b3_reg[i] - e_rnd[i][gs3_pkg::W_W-1:0];
            end
            q1_reg <= q_i;
            b1_reg <= base_i;
            d_reg  <= d_rnd[gs3_pkg::D_W-1:0];
            q2_reg <= q1_reg;
            b2_reg <= b1_reg;
            b3_reg <= b2_reg;
        end
    end

    assign w_o = w_reg;

endmodule

### design/gram_schmidt_3x3.sv
// ----------------------------------------------------------------------------
// gram_schmidt_3x3
// Classical Gram-Schmidt orthonormalization of a 3x3 Q3.28 matrix into a
// Q1.30 orthonormal matrix, fully pipelined.
// ----------------------------------------------------------------------------
// Usage: a matrix arrives on s_data with s_valid/s_ready and its result leaves
// on m_data with m_valid/m_ready; one transaction carries a whole matrix.
// The block takes one matrix every cycle while s_ready is high. A result
// passes through three unit-length stages (prescale, squares, sum, a
// 32-stage square root and 31-stage dividers), two projection stages and
// the output register. Columns are processed in sequence, each waiting on
// the unit vectors of the columns before it.
// A column that is zero on input or after projection removal comes out as
// zeros and sets degenerate.
// Reset clears the pipeline valid flags and the output valid flag; nothing
// else needs clearing. When the receiver stalls, the output register holds
// its result and the pipeline keeps moving as long as its last stage is
// empty; once a second result reaches the end, the whole pipeline freezes
// and s_ready drops until m_ready returns.
// ----------------------------------------------------------------------------
module gram_schmidt_3x3 (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  gs3_pkg::gs_in_t  s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output gs3_pkg::gs_out_t m_data
);

    localparam int LU  = gs3_pkg::UNIT_LAT;
    localparam int LP  = gs3_pkg::PROJ_LAT;
    localparam int LAT = 3 * LU + 2 * LP;
    localparam int MV  = gs3_pkg::M_W;
    localparam int WV  = gs3_pkg::W_W;
    localparam int QV  = gs3_pkg::Q_W;

    logic             pipe_en;
    logic [LAT-1:0]   vld_reg;
    logic             vld_last;
    logic             m_valid_reg;
    gs3_pkg::gs_out_t m_data_reg;

    gs3_pkg::wide_t col0 [3];
    gs3_pkg::wide_t col1 [3];
    gs3_pkg::wide_t col2 [3];

    gs3_pkg::q_t    q0 [3];
    logic           nz0;
    gs3_pkg::mag_t  mag1 [3];
    gs3_pkg::mag_t  mag2 [3];
    logic [2:0]     neg1;
    logic [2:0]     neg2;
    logic           nz1_unused;
    logic           nz2_unused;

    logic [6*MV-1:0] m_pack_d;
    logic [6*MV-1:0] m_pack_q;
    gs3_pkg::mval_t  m1a [3];
    gs3_pkg::mval_t  m2a [3];
    gs3_pkg::wide_t  m1w [3];
    gs3_pkg::wide_t  m2w [3];

    gs3_pkg::wide_t  w1 [3];
    gs3_pkg::wide_t  t2 [3];
    gs3_pkg::q_t     q1 [3];
    logic            nz1;

    logic [3*MV-1:0] m2_pack_q;
    logic [3*MV+3*WV-1:0] c2_pack_d;
    logic [3*MV+3*WV-1:0] c2_pack_q;
    gs3_pkg::mval_t  m2b [3];
    gs3_pkg::wide_t  t2b [3];

    gs3_pkg::wide_t  w2 [3];
    gs3_pkg::q_t     q2 [3];
    logic            nz2;

    logic [3*QV:0]   q0_pack_q;
    logic [3*QV:0]   q1_pack_q;
    gs3_pkg::q_t     q0f [3];
    gs3_pkg::q_t     q1f [3];
    logic            nz0f;
    logic            nz1f;

    assign vld_last = vld_reg[LAT-1];
    assign pipe_en  = !vld_last || !m_valid_reg || m_ready;
    assign s_ready  = pipe_en;

    assign col0[0] = WV'(s_data.in_r0c0);
    assign col0[1] = WV'(s_data.in_r1c0);
    assign col0[2] = WV'(s_data.in_r2c0);
    assign col1[0] = WV'(s_data.in_r0c1);
    assign col1[1] = WV'(s_data.in_r1c1);
    assign col1[2] = WV'(s_data.in_r2c1);
    assign col2[0] = WV'(s_data.in_r0c2);
    assign col2[1] = WV'(s_data.in_r1c2);
    assign col2[2] = WV'(s_data.in_r2c2);

    // Column 0 and the prescaled columns 1 and 2.
    gs3_unit u_unit0 (
        .aclk (aclk),
        .en   (pipe_en),
        .w_i  (col0),
        .q_o  (q0),
        .nz_o (nz0)
    );

    gs3_norm u_norm1 (
        .aclk  (aclk),
        .en    (pipe_en),
        .v_i   (col1),
        .mag_o (mag1),
        .neg_o (neg1),
        .nz_o  (nz1_unused)
    );

    gs3_norm u_norm2 (
        .aclk  (aclk),
        .en    (pipe_en),
        .v_i   (col2),
        .mag_o (mag2),
        .neg_o (neg2),
        .nz_o  (nz2_unused)
    );

    assign m_pack_d = {gs3_pkg::to_signed(mag1[0], neg1[0]),
                       gs3_pkg::to_signed(mag1[1], neg1[1]),
                       gs3_pkg::to_signed(mag1[2], neg1[2]),
                       gs3_pkg::to_signed(mag2[0], neg2[0]),
                       gs3_pkg::to_signed(mag2[1], neg2[1]),
                       gs3_pkg::to_signed(mag2[2], neg2[2])};

    gs3_delay #(
        .WIDTH (6 * MV),
        .DEPTH (LU - gs3_pkg::NORM_LAT)
    ) u_dly_m (
        .aclk (aclk),
        .en   (pipe_en),
        .d    (m_pack_d),
        .q    (m_pack_q)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m1a[i] = m_pack_q[6*MV-1-i*MV -: MV];
            m2a[i] = m_pack_q[3*MV-1-i*MV -: MV];
            m1w[i] = WV'(m1a[i]);
            m2w[i] = WV'(m2a[i]);
        end
    end

    gs3_proj u_proj1 (
        .aclk   (aclk),
        .en     (pipe_en),
        .q_i    (q0),
        .m_i    (m1a),
        .base_i (m1w),
        .w_o    (w1)
    );

    gs3_proj u_proj2a (
        .aclk   (aclk),
        .en     (pipe_en),
        .q_i    (q0),
        .m_i    (m2a),
        .base_i (m2w),
        .w_o    (t2)
    );

    gs3_unit u_unit1 (
        .aclk (aclk),
        .en   (pipe_en),
        .w_i  (w1),
        .q_o  (q1),
        .nz_o (nz1)
    );

    // Column 2 and its partial residue wait for the second unit vector.
    // The column is first brought in step with the partial residue.
    gs3_delay #(
        .WIDTH (3 * MV),
        .DEPTH (LP)
    ) u_dly_m2 (
        .aclk (aclk),
        .en   (pipe_en),
        .d    (m_pack_q[3*MV-1:0]),
        .q    (m2_pack_q)
    );

    assign c2_pack_d = {m2_pack_q, t2[0], t2[1], t2[2]};

    gs3_delay #(
        .WIDTH (3 * MV + 3 * WV),
        .DEPTH (LU)
    ) u_dly_c2 (
        .aclk (aclk),
        .en   (pipe_en),
        .d    (c2_pack_d),
        .q    (c2_pack_q)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m2b[i] = c2_pack_q[3*MV+3*WV-1-i*MV -: MV];
            t2b[i] = c2_pack_q[3*WV-1-i*WV -: WV];
        end
    end

    gs3_proj u_proj2b (
        .aclk   (aclk),
        .en     (pipe_en),
        .q_i    (q1),
        .m_i    (m2b),
        .base_i (t2b),
        .w_o    (w2)
    );

    gs3_unit u_unit2 (
        .aclk (aclk),
        .en   (pipe_en),
        .w_i  (w2),
        .q_o  (q2),
        .nz_o (nz2)
    );

    gs3_delay #(
        .WIDTH (3 * QV + 1),
        .DEPTH (2 * LU + 2 * LP)
    ) u_dly_q0 (
        .aclk (aclk),
        .en   (pipe_en),
        .d    ({q0[0], q0[1], q0[2], nz0}),
        .q    (q0_pack_q)
    );

    gs3_delay #(
        .WIDTH (3 * QV + 1),
        .DEPTH (LU + LP)
    ) u_dly_q1 (
        .aclk (aclk),
        .en   (pipe_en),
        .d    ({q1[0], q1[1], q1[2], nz1}),
        .q    (q1_pack_q)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            q0f[i] = q0_pack_q[3*QV-i*QV -: QV];
            q1f[i] = q1_pack_q[3*QV-i*QV -: QV];
        end
        nz0f = q0_pack_q[0];
        nz1f = q1_pack_q[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pipe_en) begin
                vld_reg <= {vld_reg[LAT-2:0], s_valid};
            end
            if (pipe_en && vld_last) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en && vld_last) begin
            m_data_reg.out_r0c0   <= q0f[0];
            m_data_reg.out_r1c0   <= q0f[1];
            m_data_reg.out_r2c0   <= q0f[2];
            m_data_reg.out_r0c1   <= q1f[0];
            m_data_reg.out_r1c1   <= q1f[1];
            m_data_reg.out_r2c1   <= q1f[2];
            m_data_reg.out_r0c2   <= q2[0];
            m_data_reg.out_r1c2   <= q2[1];
            m_data_reg.out_r2c2   <= q2[2];
            m_data_reg.degenerate <= !(nz0f && nz1f && nz2);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A nonzero column always normalizes to a nonzero vector.
    a_zero_col_flagged: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.out_r0c0 == 0 && m_data.out_r1c0 == 0 &&
         m_data.out_r2c0 == 0) |-> m_data.degenerate)
        else $error("zero column 0 without degenerate flag");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid_reg && !m_ready && vld_last))
        else $error("input stalled while the output side could move");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (pipe_en && vld_last) |=> m_valid_reg)
        else $error("finished transaction was not loaded into the output register");

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.out_r0c1 <= 32'sd1073741824 &&
                     m_data.out_r0c1 >= -32'sd1073741824))
        else $error("unit vector element above one");

endmodule
